// File: hw/rtl/srecord_s1_s9_encoder_macros.svh
// Assertion macros for the S1/S9 record encoder.
`ifndef SRECORD_S1_S9_ENCODER_MACROS_SVH
`define SRECORD_S1_S9_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define SREC_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define SREC_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define SREC_ASSERT_IMPL(label, clk, rst_n, a, c)
`define SREC_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// File: hw/rtl/srec_pkg.sv
// Shared constants, types and functions of the S1/S9 record encoder.
`default_nettype none
package srec_pkg;
	localparam int RECORD_BYTES = 16;
	localparam int COUNT_W = $clog2(RECORD_BYTES + 1);
	localparam int IDX_W = $clog2(RECORD_BYTES > 1 ? RECORD_BYTES : 2);
	localparam int POS_W = $clog2(2 * RECORD_BYTES + 12);

	localparam logic [6:0] CHAR_S = 7'h53;
	localparam logic [6:0] CHAR_1 = 7'h31;
	localparam logic [6:0] CHAR_9 = 7'h39;
	localparam logic [6:0] CHAR_CR = 7'h0D;
	localparam logic [6:0] CHAR_LF = 7'h0A;

	localparam logic CTRL_IDLE = 1'b0;
	localparam logic CTRL_EMIT = 1'b1;

	typedef struct packed {
		logic take;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic emits;
		logic at_last;
	} status_t;

	function automatic logic [6:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) begin
			hex_char = 7'h30 + {3'd0, v};
		end else begin
			hex_char = 7'h37 + {3'd0, v};
		end
	endfunction
endpackage
`default_nettype wire

// File: hw/rtl/srec_in_if.sv
// Input channel of the encoder: one data byte or transfer address per item.
`default_nettype none
interface srec_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [15:0] address;
	logic [7:0] data_byte;
	logic run_last;

	modport source(output valid, output operation, output address, output data_byte,
		output run_last, input ready);
	modport sink(input valid, input operation, input address, input data_byte,
		input run_last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/srec_out_if.sv
// Output channel of the encoder: one record character per item.
`default_nettype none
interface srec_out_if;
	logic valid;
	logic ready;
	logic [6:0] out_char;
	logic last;

	modport source(output valid, output out_char, output last, input ready);
	modport sink(input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/srecord_s1_s9_encoder.sv
// Top level of the S1/S9 record encoder: controller, datapath and assertions.
//
//  channel  direction  payload                                   handshake
//  din      sink       operation, address, data_byte, run_last  valid/ready
//  dout     source     out_char, last                            valid/ready
//
// A data byte that does not close a record is buffered; the input stays ready.
// A record then goes out one character per cycle unless dout stalls: 12 + 2n
// chars for n bytes in S1 (44 when full), 11 in S9, set by the character counter.
// The input is ready only while no record is being sent; the output register
// holds a stalled character, and the buffer count clears at reset.
`default_nettype none
`include "srecord_s1_s9_encoder_macros.svh"
module srecord_s1_s9_encoder
	import srec_pkg::*;
(
	input wire         clk,
	input wire         arst_n,
	srec_in_if.sink    din,
	srec_out_if.source dout
);
	cmd_t    cmd;
	status_t status;

	srec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.status    (status),
		.cmd       (cmd)
	);

	srec_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (din.operation),
		.address   (din.address),
		.data_byte (din.data_byte),
		.run_last  (din.run_last),
		.status    (status),
		.out_char  (dout.out_char),
		.last      (dout.last)
	);

	`SREC_ASSERT_NEXT(a_emit_blocks_input, clk, arst_n, cmd.take && status.emits, !din.ready)
	`SREC_ASSERT_IMPL(a_no_step_when_idle, clk, arst_n, din.ready, !cmd.step)
	`SREC_ASSERT_IMPL(a_last_is_lf, clk, arst_n, dout.valid && dout.last, dout.out_char == CHAR_LF)
endmodule
`default_nettype wire

// File: hw/rtl/srec_ctrl.sv
// Controller: accepts items while idle and paces the record characters.
`default_nettype none
module srec_ctrl
	import srec_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  wire     out_ready,
	input  status_t status,
	output cmd_t    cmd
);
	logic state_q;
	logic out_valid_q;

	assign in_ready = (state_q == CTRL_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.take = in_valid && in_ready;
		cmd.step = (state_q == CTRL_EMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTRL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				CTRL_IDLE: begin
					if (cmd.take && status.emits) begin
						state_q <= CTRL_EMIT;
					end
				end
				CTRL_EMIT: begin
					if (cmd.step && status.at_last) begin
						state_q <= CTRL_IDLE;
					end
				end
				default: state_q <= CTRL_IDLE;
			endcase
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/srec_dp.sv
// Datapath: byte buffer, checksum, record fields and character generation.
`default_nettype none
module srec_dp
	import srec_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  cmd_t        cmd,
	input  wire         operation,
	input  wire  [15:0] address,
	input  wire  [7:0]  data_byte,
	input  wire         run_last,
	output status_t     status,
	output logic [6:0]  out_char,
	output logic        last
);
	logic [7:0]         buffer_q [RECORD_BYTES];
	logic [COUNT_W-1:0] count_q;
	logic [15:0]        start_q;
	logic [7:0]         sum_q;
	logic [15:0]        emit_addr_q;
	logic [7:0]         emit_cnt_q;
	logic [7:0]         emit_chk_q;
	logic               emit_s9_q;
	logic [POS_W-1:0]   data_end_q;
	logic [POS_W-1:0]   last_pos_q;
	logic [POS_W-1:0]   pos_q;
	logic [6:0]         char_q;
	logic               last_q;

	logic [COUNT_W-1:0] new_count;
	logic               first;
	logic [15:0]        start_n;
	logic [7:0]         sum_n;
	logic [7:0]         cnt_n;
	logic [POS_W-1:0]   data_end_n;
	logic [POS_W-1:0]   data_off;
	logic [7:0]         data_sel;
	logic [3:0]         nib;
	logic [6:0]         char_n;

	always_comb begin
		new_count = count_q + COUNT_W'(1);
		first = (count_q == '0);
		start_n = first ? address : start_q;
		sum_n = (first ? (address[15:8] + address[7:0]) : sum_q) + data_byte;
		cnt_n = 8'(new_count) + 8'd3;
		data_end_n = POS_W'(8) + POS_W'({new_count, 1'b0});
		status.emits = operation || run_last || (new_count == COUNT_W'(RECORD_BYTES));
		status.at_last = (pos_q == last_pos_q);
	end

	always_comb begin
		data_off = pos_q - POS_W'(8);
		data_sel = buffer_q[IDX_W'(data_off >> 1)];
		nib = 4'd0;
		char_n = CHAR_LF;
		priority if (pos_q == POS_W'(0)) begin
			char_n = CHAR_S;
		end else if (pos_q == POS_W'(1)) begin
			char_n = emit_s9_q ? CHAR_9 : CHAR_1;
		end else if (pos_q < POS_W'(4)) begin
			nib = pos_q[0] ? emit_cnt_q[3:0] : emit_cnt_q[7:4];
			char_n = hex_char(nib);
		end else if (pos_q < POS_W'(8)) begin
			unique case (pos_q[1:0])
				2'd0: nib = emit_addr_q[15:12];
				2'd1: nib = emit_addr_q[11:8];
				2'd2: nib = emit_addr_q[7:4];
				default: nib = emit_addr_q[3:0];
			endcase
			char_n = hex_char(nib);
		end else if (pos_q < data_end_q) begin
			nib = pos_q[0] ? data_sel[3:0] : data_sel[7:4];
			char_n = hex_char(nib);
		end else if (pos_q == data_end_q) begin
			char_n = hex_char(emit_chk_q[7:4]);
		end else if (pos_q == data_end_q + POS_W'(1)) begin
			char_n = hex_char(emit_chk_q[3:0]);
		end else if (pos_q == data_end_q + POS_W'(2)) begin
			char_n = emit_s9_q ? CHAR_LF : CHAR_CR;
		end else begin
			char_n = CHAR_LF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			start_q <= '0;
		end else if (cmd.take && !operation) begin
			count_q <= status.emits ? '0 : new_count;
			start_q <= start_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pos_q <= '0;
			if (operation) begin
				emit_s9_q <= 1'b1;
				emit_addr_q <= address;
				emit_cnt_q <= 8'd3;
				emit_chk_q <= ~(8'd3 + address[15:8] + address[7:0]);
				data_end_q <= POS_W'(8);
				last_pos_q <= POS_W'(10);
			end else begin
				buffer_q[IDX_W'(count_q)] <= data_byte;
				sum_q <= sum_n;
				emit_s9_q <= 1'b0;
				emit_addr_q <= start_n;
				emit_cnt_q <= cnt_n;
				emit_chk_q <= ~(sum_n + cnt_n);
				data_end_q <= data_end_n;
				last_pos_q <= data_end_n + POS_W'(3);
			end
		end else if (cmd.step) begin
			pos_q <= pos_q + POS_W'(1);
			char_q <= char_n;
			last_q <= status.at_last;
		end
	end

	assign out_char = char_q;
	assign last = last_q;
endmodule
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the S1/S9 record encoder.
`timescale 1ns / 1ps
module tb;
	import srec_pkg::*;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_TRANSFER = 1'b1;
	localparam int RANDOM_ITEMS = 106;
	localparam int LONG_HOLD = 400;

	typedef bit bool_t;

	typedef struct packed {
		logic [6:0] code;
		logic last;
	} rec_char_t;

	typedef struct {
		logic op;
		logic [15:0] addr;
		logic [7:0] data;
		logic run_last;
		string text;
	} stim_row_t;

	logic clk;
	logic arst_n;

	srec_in_if din_if();
	srec_out_if dout_if();

	srecord_s1_s9_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_if),
		.dout(dout_if)
	);

	rec_char_t expected_chars[$];
	rec_char_t record_text[$];
	stim_row_t directed_rows[$];
	logic [7:0] held_bytes[RECORD_BYTES];
	int held_count;
	logic [15:0] record_addr;
	int mismatch_count;
	bit quiet;
	bit hold_request;

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 40) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [6:0] ascii_nibble(input logic [3:0] n);
		logic [7:0] c;
		if (n > 4'd9) begin
			c = "A" + {4'd0, n} - 8'd10;
		end else begin
			c = "0" + {4'd0, n};
		end
		return c[6:0];
	endfunction

	function automatic void put_char(input logic [6:0] code, input logic last);
		rec_char_t rc;
		rc.code = code;
		rc.last = last;
		record_text.push_back(rc);
	endfunction

	function automatic void put_byte(input logic [7:0] v);
		put_char(ascii_nibble(v[7:4]), 1'b0);
		put_char(ascii_nibble(v[3:0]), 1'b0);
	endfunction

	// Updates the buffered record and leaves the characters of any record it closes in
	// record_text.
	function automatic void encode_item(input logic op, input logic [15:0] addr,
		input logic [7:0] data, input logic run_last);
		logic [7:0] sum;
		logic [7:0] count;
		record_text.delete();
		if (op == OP_TRANSFER) begin
			sum = 8'd3 + addr[7:0] + addr[15:8];
			put_char(CHAR_S, 1'b0);
			put_char(CHAR_9, 1'b0);
			put_byte(8'd3);
			put_byte(addr[15:8]);
			put_byte(addr[7:0]);
			put_byte(~sum);
			put_char(CHAR_LF, 1'b1);
			return;
		end
		if (held_count == 0) begin
			record_addr = addr;
		end
		held_bytes[held_count] = data;
		held_count++;
		if (held_count == RECORD_BYTES || run_last) begin
			count = 8'(held_count + 3);
			sum = count + record_addr[7:0] + record_addr[15:8];
			put_char(CHAR_S, 1'b0);
			put_char(CHAR_1, 1'b0);
			put_byte(count);
			put_byte(record_addr[15:8]);
			put_byte(record_addr[7:0]);
			for (int i = 0; i < held_count; i++) begin
				sum += held_bytes[i];
				put_byte(held_bytes[i]);
			end
			put_byte(~sum);
			put_char(CHAR_CR, 1'b0);
			put_char(CHAR_LF, 1'b1);
			held_count = 0;
		end
	endfunction

	function automatic void add_row(input logic op, input logic [15:0] addr,
		input logic [7:0] data, input logic run_last, input string text);
		stim_row_t r;
		r.op = op;
		r.addr = addr;
		r.data = data;
		r.run_last = run_last;
		r.text = text;
		directed_rows.push_back(r);
	endfunction

	task automatic send_item(input logic op, input logic [15:0] addr, input logic [7:0] data,
		input logic run_last, input string text);
		int gap;
		rec_char_t rc;
		gap = idle_len();
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.operation <= op;
		din_if.address <= addr;
		din_if.data_byte <= data;
		din_if.run_last <= run_last;
		do @(posedge clk); while (!din_if.ready);
		encode_item(op, addr, data, run_last);
		if (text.len() == 0) begin
			foreach (record_text[k]) begin
				expected_chars.push_back(record_text[k]);
			end
		end else begin
			for (int k = 0; k < text.len(); k++) begin
				rc.code = 7'(text[k]);
				rc.last = 1'b0;
				expected_chars.push_back(rc);
			end
			if (op == OP_DATA) begin
				rc.code = CHAR_CR;
				expected_chars.push_back(rc);
			end
			rc.code = CHAR_LF;
			rc.last = 1'b1;
			expected_chars.push_back(rc);
		end
	endtask

	initial begin
		rec_char_t want;
		int stall_left;
		stall_left = 0;
		dout_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (dout_if.valid && dout_if.ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character %h with nothing expected",
						dout_if.out_char));
				end else begin
					want = expected_chars.pop_front();
					if (dout_if.out_char !== want.code) begin
						report_mismatch($sformatf("out_char %h, expected %h",
							dout_if.out_char, want.code));
					end
					if (dout_if.last !== want.last) begin
						report_mismatch($sformatf("last %b, expected %b",
							dout_if.last, want.last));
					end
				end
			end
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 1) == 0) begin
				stall_left = idle_len();
			end
			if (stall_left > 0) begin
				stall_left--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int sent;
		int run_len;
		bool_t tidy;
		logic [15:0] base;
		logic run_last;
		bit drained;
		bit held;
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.operation = OP_DATA;
		din_if.address = '0;
		din_if.data_byte = '0;
		din_if.run_last = 1'b0;
		mismatch_count = 0;
		held_count = 0;
		record_addr = '0;
		quiet = 1'b0;
		hold_request = 1'b0;
		drained = 1'b0;
		held = 1'b0;

		add_row(OP_TRANSFER, 16'h0000, 8'h00, 1'b0, "S9030000FC");
		add_row(OP_TRANSFER, 16'hFFFF, 8'hFF, 1'b1, "S903FFFFFE");
		add_row(OP_DATA, 16'h0000, 8'h00, 1'b1, "S104000000FB");
		add_row(OP_DATA, 16'hFFFF, 8'hFF, 1'b1, "S104FFFFFFFE");
		// A full record whose last byte also ends the run; later addresses are ignored.
		for (int i = 0; i < RECORD_BYTES; i++) begin
			add_row(OP_DATA, (i == 0) ? 16'h1234 : ((i % 2) ? 16'hFFFF : 16'h0000),
				8'(i * 8'h11 + 8'h07), (i == RECORD_BYTES - 1), "");
		end
		// A transfer between bytes of a run leaves the buffered bytes in place.
		add_row(OP_DATA, 16'hFFFE, 8'hA5, 1'b0, "");
		add_row(OP_DATA, 16'h0000, 8'h5A, 1'b0, "");
		add_row(OP_TRANSFER, 16'hBEEF, 8'hFF, 1'b1, "S903BEEF4F");
		add_row(OP_DATA, 16'h7777, 8'h3C, 1'b1, "");

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			send_item(directed_rows[r].op, directed_rows[r].addr, directed_rows[r].data,
				directed_rows[r].run_last, directed_rows[r].text);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (!drained && sent >= 40) begin
				drained = 1'b1;
				din_if.valid <= 1'b0;
				do @(posedge clk); while (expected_chars.size() != 0);
			end
			if (!held && sent >= 70) begin
				held = 1'b1;
				hold_request = 1'b1;
			end
			quiet = (sent >= 95 && sent < 115);
			if ($urandom_range(0, 99) < 12) begin
				send_item(OP_TRANSFER, 16'($urandom), 8'($urandom), 1'($urandom), "");
				sent++;
			end else begin
				run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
					: $urandom_range(1, 16);
				base = 16'($urandom);
				tidy = ($urandom_range(0, 9) != 0);
				for (int i = 0; i < run_len; i++) begin
					if (i == run_len - 1) begin
						run_last = ($urandom_range(0, 7) != 0);
					end else begin
						run_last = ($urandom_range(0, 19) == 0);
					end
					send_item(OP_DATA, tidy ? base + 16'(i) : 16'($urandom), 8'($urandom),
						run_last, "");
					sent++;
					if ($urandom_range(0, 29) == 0) begin
						send_item(OP_TRANSFER, 16'($urandom), 8'($urandom), 1'($urandom), "");
						sent++;
					end
				end
			end
		end
		quiet = 1'b0;
		din_if.valid <= 1'b0;

		while (expected_chars.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
